// ===== sv/brb_pkg.sv =====
// Shared types, codes and helpers for the byte ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package brb_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int LEN_W = 6;
  localparam int BYTE_W = 8;
  localparam int CFG_W = 7;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_ROOM  = 2'd1,
    STAT_BAD_ARG  = 2'd2,
    STAT_NOT_OPEN = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // Clamp a capacity write to between 2 and the number of slots that exist.
  function automatic logic [CAP_W-1:0] cap_sat(input logic [CFG_W-1:0] v);
    logic [CAP_W-1:0] r;
    if (v < CFG_W'(2)) r = CAP_W'(2);
    else if (v > CFG_W'(DEPTH)) r = CAP_W'(DEPTH);
    else r = CAP_W'(v);
    return r;
  endfunction

  // Advance a ring pointer, wrapping at the current capacity.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] s;
    s = CAP_W'(p) + CAP_W'(1);
    return (s == c) ? '0 : PTR_W'(s);
  endfunction

endpackage

`default_nettype wire

// ===== sv/byte_ring_buffer_core.sv =====
// Byte ring buffer top level: command decode, pointer state and read burst sequencer.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------------
//  command  | cmd, length, data_byte                    | start && !busy
//  result   | status, read_byte, byte_valid, last,      | done, one cycle, no stall
//           | transferred, free_space, used_space       |
//  config   | cfg_data (capacity)                       | cfg_valid && cfg_ready
//
// Write begin, write byte, clear and rejected requests give one result in the cycle
// after acceptance and keep busy low, so they run at one request per cycle.
// A read of n bytes gives n results on consecutive cycles, the first in the cycle after
// acceptance; busy stays high until the last byte is fetched, as storage has a single read port.
// A capacity write is held off while busy or start is high.
// Reset is synchronous; it empties the ring and sets capacity to its full value.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module byte_ring_buffer_core
  import brb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd,
  input  wire logic [LEN_W-1:0]  length,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output logic                   done,
  output logic [1:0]             status,
  output logic [BYTE_W-1:0]      read_byte,
  output logic                   byte_valid,
  output logic                   last,
  output logic [LEN_W-1:0]       transferred,
  output logic [LEN_W-1:0]       free_space,
  output logic [LEN_W-1:0]       used_space
);

  state_t            state, state_next;
  logic [PTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]  pend_ptr, pend_ptr_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [CAP_W-1:0]  cap, cap_next;
  logic [PTR_W-1:0]  burst_addr, burst_addr_next;
  logic [LEN_W-1:0]  burst_cnt, burst_cnt_next;
  logic [LEN_W-1:0]  burst_len, burst_len_next;

  logic              done_next, byte_valid_next, last_next;
  status_t           status_q, status_next;
  logic [LEN_W-1:0]  transferred_next;

  logic              accept, cfg_write;
  logic [CAP_W-1:0]  used, free;
  logic [PTR_W-1:0]  pend_inc;
  logic [CAP_W-1:0]  byte_cnt;
  logic [CAP_W-1:0]  rd_n;
  logic [CAP_W:0]    rd_end;

  logic              ram_we, ram_re;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_q;

  assign busy      = (state == S_READ);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // Committed fill level from the published pointers.
  always_comb begin
    if (wr_ptr >= rd_ptr) used = CAP_W'(wr_ptr) - CAP_W'(rd_ptr);
    else used = cap - (CAP_W'(rd_ptr) - CAP_W'(wr_ptr));
    free = cap - CAP_W'(1) - used;
  end

  assign used_space = LEN_W'(used);
  assign free_space = LEN_W'(free);
  assign status     = status_q;
  assign read_byte  = byte_valid ? ram_q : '0;

  assign pend_inc = ptr_inc(pend_ptr, cap);
  // Bytes of the open message so far; modular, the true value stays below cap.
  assign byte_cnt = (CAP_W'(pend_inc) >= CAP_W'(wr_ptr)) ?
                    CAP_W'(pend_inc) - CAP_W'(wr_ptr) :
                    CAP_W'(pend_inc) + cap - CAP_W'(wr_ptr);
  assign rd_n     = (used > CAP_W'(length)) ? CAP_W'(length) : used;
  assign rd_end   = (CAP_W + 1)'(rd_ptr) + (CAP_W + 1)'(rd_n);

  always_comb begin
    state_next       = state;
    rd_ptr_next      = rd_ptr;
    wr_ptr_next      = wr_ptr;
    pend_ptr_next    = pend_ptr;
    remaining_next   = remaining;
    cap_next         = cap;
    burst_addr_next  = burst_addr;
    burst_cnt_next   = burst_cnt;
    burst_len_next   = burst_len;
    done_next        = 1'b0;
    status_next      = STAT_OK;
    byte_valid_next  = 1'b0;
    last_next        = 1'b1;
    transferred_next = '0;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = burst_addr;

    unique case (state)
      S_IDLE: begin
        if (cfg_write) begin
          cap_next       = cap_sat(cfg_data);
          rd_ptr_next    = '0;
          wr_ptr_next    = '0;
          pend_ptr_next  = '0;
          remaining_next = '0;
        end else if (accept) begin
          done_next = 1'b1;
          unique case (cmd_t'(cmd))
            CMD_BEGIN: begin
              if (length == '0) begin
                status_next = STAT_BAD_ARG;
              end else begin
                // a new begin drops any unfinished message
                pend_ptr_next = wr_ptr;
                if (CAP_W'(length) > free) begin
                  status_next    = STAT_NO_ROOM;
                  remaining_next = '0;
                end else begin
                  remaining_next   = length;
                  transferred_next = length;
                end
              end
            end
            CMD_BYTE: begin
              if (remaining == '0) begin
                status_next = STAT_NOT_OPEN;
              end else begin
                ram_we           = 1'b1;
                pend_ptr_next    = pend_inc;
                remaining_next   = remaining - LEN_W'(1);
                transferred_next = LEN_W'(byte_cnt);
                if (remaining == LEN_W'(1)) wr_ptr_next = pend_inc;
              end
            end
            CMD_READ: begin
              if (length == '0) begin
                status_next = STAT_BAD_ARG;
              end else if (used == '0) begin
                status_next = STAT_NO_ROOM;
              end else begin
                // first byte is fetched now; pointer moves past the whole burst
                ram_re           = 1'b1;
                ram_raddr        = rd_ptr;
                byte_valid_next  = 1'b1;
                transferred_next = LEN_W'(1);
                last_next        = (rd_n == CAP_W'(1));
                burst_addr_next  = ptr_inc(rd_ptr, cap);
                burst_cnt_next   = LEN_W'(1);
                burst_len_next   = LEN_W'(rd_n);
                rd_ptr_next      = (rd_end >= (CAP_W + 1)'(cap)) ?
                                   PTR_W'(rd_end - (CAP_W + 1)'(cap)) : PTR_W'(rd_end);
                if (rd_n != CAP_W'(1)) state_next = S_READ;
              end
            end
            CMD_CLEAR: begin
              rd_ptr_next    = '0;
              wr_ptr_next    = '0;
              pend_ptr_next  = '0;
              remaining_next = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        ram_re           = 1'b1;
        done_next        = 1'b1;
        byte_valid_next  = 1'b1;
        burst_cnt_next   = burst_cnt + LEN_W'(1);
        transferred_next = burst_cnt + LEN_W'(1);
        last_next        = (burst_cnt + LEN_W'(1) == burst_len);
        burst_addr_next  = ptr_inc(burst_addr, cap);
        if (burst_cnt + LEN_W'(1) == burst_len) state_next = S_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      pend_ptr  <= '0;
      remaining <= '0;
      cap       <= cap_sat(CFG_W'(DEPTH));
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      rd_ptr    <= rd_ptr_next;
      wr_ptr    <= wr_ptr_next;
      pend_ptr  <= pend_ptr_next;
      remaining <= remaining_next;
      cap       <= cap_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    burst_addr  <= burst_addr_next;
    burst_cnt   <= burst_cnt_next;
    burst_len   <= burst_len_next;
    status_q    <= status_next;
    byte_valid  <= byte_valid_next;
    last        <= last_next;
    transferred <= transferred_next;
  end

  // Reads touch committed entries only, which were written cycles earlier: no bypass.
  brb_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_ptr),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  a_burst_feeds_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (done && byte_valid))
    else $error("read burst cycle produced no byte result");

  a_error_is_single: assert property (@(posedge clk) disable iff (rst)
    (done && status_q != STAT_OK) |-> (last && !byte_valid))
    else $error("rejected request gave a byte or a non-final result");

  a_space_sums: assert property (@(posedge clk) disable iff (rst)
    (CAP_W'(used) + CAP_W'(free) + CAP_W'(1) == cap))
    else $error("used plus free does not match capacity");

  a_ptrs_in_ring: assert property (@(posedge clk) disable iff (rst)
    (CAP_W'(rd_ptr) < cap) && (CAP_W'(wr_ptr) < cap) && (CAP_W'(pend_ptr) < cap))
    else $error("ring pointer beyond capacity");

  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    (busy && last_next) |=> (!busy && last))
    else $error("burst end and last flag disagree");

endmodule

`default_nettype wire

// ===== sv/brb_ram.sv =====
// Byte storage: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module brb_ram
  import brb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [PTR_W-1:0]  waddr,
  input  wire logic [BYTE_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [PTR_W-1:0]  raddr,
  output logic      [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
